>>> hdl/atatf_pkg.sv
// ATA task-file command issue: shared types, register codes and opcodes.
// Used by atatf_decode, atatf_seq and ata_taskfile_command_issue_top.
`timescale 1ns / 1ps
`default_nettype none

package atatf_pkg;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_DRIVE = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_WPROT    = 2'd3;

    localparam logic [1:0] MODE_CHS   = 2'd0;
    localparam logic [1:0] MODE_LBA28 = 2'd1;
    localparam logic [1:0] MODE_LBA48 = 2'd2;

    localparam logic [3:0] REG_COUNT    = 4'd2;
    localparam logic [3:0] REG_LBA0     = 4'd3;
    localparam logic [3:0] REG_LBA1     = 4'd4;
    localparam logic [3:0] REG_LBA2     = 4'd5;
    localparam logic [3:0] REG_DEVSEL   = 4'd6;
    localparam logic [3:0] REG_COMMAND  = 4'd7;
    localparam logic [3:0] REG_COUNT_HI = 4'd8;
    localparam logic [3:0] REG_LBA3     = 4'd9;
    localparam logic [3:0] REG_LBA4     = 4'd10;
    localparam logic [3:0] REG_LBA5     = 4'd11;

    localparam logic [2:0] CFG_PRESENT  = 3'd0;
    localparam logic [2:0] CFG_ATAPI    = 3'd1;
    localparam logic [2:0] CFG_LBA      = 3'd2;
    localparam logic [2:0] CFG_POSITION = 3'd3;
    localparam logic [2:0] CFG_SIZE0    = 3'd4;
    localparam logic [2:0] CFG_SIZE1    = 3'd5;
    localparam logic [2:0] CFG_SIZE2    = 3'd6;
    localparam logic [2:0] CFG_SIZE3    = 3'd7;

    localparam logic [31:0] LBA48_START = 32'h1000_0000;
    localparam logic [7:0]  DEVSEL_LBA  = 8'hE0;
    localparam logic [7:0]  DEVSEL_CHS  = 8'hA0;

    localparam logic [7:0] CMD_READ_PIO      = 8'h20;
    localparam logic [7:0] CMD_READ_DMA      = 8'hC8;
    localparam logic [7:0] CMD_WRITE_PIO     = 8'h30;
    localparam logic [7:0] CMD_WRITE_DMA     = 8'hCA;
    localparam logic [7:0] CMD_READ_PIO_EXT  = 8'h24;
    localparam logic [7:0] CMD_READ_DMA_EXT  = 8'h25;
    localparam logic [7:0] CMD_WRITE_PIO_EXT = 8'h34;
    localparam logic [7:0] CMD_WRITE_DMA_EXT = 8'h35;

    // ceil(2^34 / 63): exact quotient by 63 for any 28-bit dividend
    localparam logic [28:0] RECIP63     = 29'd272696337;
    localparam int          RECIP_SHIFT = 34;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_WRITES = 2'd2;

    // Write sequence positions: devsel, LBA48 high part, count, lba0-2, command
    localparam logic [3:0] SEQ_DEVSEL   = 4'd0;
    localparam logic [3:0] SEQ_HIGH_END = 4'd4;
    localparam logic [3:0] SEQ_COUNT    = 4'd5;
    localparam logic [3:0] SEQ_LAST     = 4'd9;

    typedef struct packed {
        logic [3:0]       present;
        logic [3:0]       atapi;
        logic [3:0]       lba;
        logic [7:0]       position;
        logic [3:0][31:0] size;
    } cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] status;
        logic       ch;
        logic [1:0] mode;
        logic [7:0] devsel;
        logic [7:0] cnt;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] opcode;
    } cmd_t;

    function automatic logic [3:0] seq_offset(input logic [3:0] pos);
        logic [3:0] off;
        case (pos)
            4'd0:    off = REG_DEVSEL;
            4'd1:    off = REG_COUNT_HI;
            4'd2:    off = REG_LBA3;
            4'd3:    off = REG_LBA4;
            4'd4:    off = REG_LBA5;
            4'd5:    off = REG_COUNT;
            4'd6:    off = REG_LBA0;
            4'd7:    off = REG_LBA1;
            4'd8:    off = REG_LBA2;
            default: off = REG_COMMAND;
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

>>> hdl/ata_taskfile_command_issue_top.sv
// Top level of the ATA task-file command issue block: configuration
// registers, request decode and write sequencer. Depends on atatf_pkg.
`timescale 1ns / 1ps
`default_nettype none

// A request passes an input register and a decode stage, then the sequencer
// issues its results one per cycle while out_stall is low: ten task-file
// writes for LBA48, six for LBA28 or CHS, a single status transfer for a
// rejected request, and none for a read from an ATAPI drive, which decode
// drops at once. The sequencer holds the request in its descriptor register
// and each result in the output register; a request has ten results at most.
// The next request is decoded while the current one is issuing, so results
// of back-to-back requests follow without a gap.

module ata_taskfile_command_issue_top
    import atatf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        direction,
    input  wire logic        use_dma,
    input  wire logic [7:0]  drive_number,
    input  wire logic [31:0] block_address,
    input  wire logic [7:0]  sector_count,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             is_reg_write,
    output logic             channel_select,
    output logic [3:0]       reg_offset,
    output logic [7:0]       reg_value,
    output logic [1:0]       status_code,
    output logic [1:0]       addr_mode,
    output logic             last_item
);

    cfg_t cfg_reg;
    logic seq_free;
    logic cmd_valid;
    cmd_t cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_PRESENT:  cfg_reg.present  <= cfg_data[3:0];
                CFG_ATAPI:    cfg_reg.atapi    <= cfg_data[3:0];
                CFG_LBA:      cfg_reg.lba      <= cfg_data[3:0];
                CFG_POSITION: cfg_reg.position <= cfg_data[7:0];
                CFG_SIZE0:    cfg_reg.size[0]  <= cfg_data;
                CFG_SIZE1:    cfg_reg.size[1]  <= cfg_data;
                CFG_SIZE2:    cfg_reg.size[2]  <= cfg_data;
                CFG_SIZE3:    cfg_reg.size[3]  <= cfg_data;
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    atatf_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .direction     (direction),
        .use_dma       (use_dma),
        .drive_number  (drive_number),
        .block_address (block_address),
        .sector_count  (sector_count),
        .cfg           (cfg_reg),
        .seq_free      (seq_free),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd)
    );

    atatf_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .seq_free       (seq_free),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .is_reg_write   (is_reg_write),
        .channel_select (channel_select),
        .reg_offset     (reg_offset),
        .reg_value      (reg_value),
        .status_code    (status_code),
        .addr_mode      (addr_mode),
        .last_item      (last_item)
    );

endmodule

`default_nettype wire

>>> hdl/atatf_decode.sv
// Request input register and request check / address translation.
// Depends on atatf_pkg; feeds one command descriptor to atatf_seq.
`timescale 1ns / 1ps
`default_nettype none

module atatf_decode
    import atatf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        direction,
    input  wire logic        use_dma,
    input  wire logic [7:0]  drive_number,
    input  wire logic [31:0] block_address,
    input  wire logic [7:0]  sector_count,
    input  wire cfg_t        cfg,
    input  wire logic        seq_free,
    output logic             cmd_valid,
    output cmd_t             cmd
);

    logic        req_valid_reg;
    logic        dir_reg;
    logic        dma_reg;
    logic [7:0]  drv_reg;
    logic [31:0] lba_reg;
    logic [7:0]  cnt_reg;

    logic        consumed;
    logic        load;
    logic [1:0]  drv_idx;
    logic        drv_ok;
    logic [32:0] end_sum;
    logic        range_bad;
    logic        is_atapi;
    logic [27:0] chs_x;
    logic [56:0] prod;
    logic [22:0] track;
    logic [28:0] track63;
    logic [28:0] rem_full;
    logic [7:0]  sector;
    logic [18:0] cyl;
    logic [3:0]  head;

    assign drv_idx   = drv_reg[1:0];
    assign drv_ok    = (drv_reg[7:2] == 6'd0) && cfg.present[drv_idx];
    assign end_sum   = {1'b0, lba_reg} + {25'd0, cnt_reg};
    assign range_bad = end_sum > {1'b0, cfg.size[drv_idx]};
    assign is_atapi  = cfg.atapi[drv_idx];

    // CHS translation: divide by 63 through the reciprocal
    assign chs_x    = lba_reg[27:0];
    assign prod     = 57'(chs_x) * 57'(RECIP63);
    assign track    = prod[RECIP_SHIFT +: 23];
    assign track63  = {track, 6'd0} - {6'd0, track};
    assign rem_full = {1'b0, chs_x} - track63;
    assign sector   = {2'd0, rem_full[5:0]} + 8'd1;
    assign cyl      = track[22:4];
    assign head     = track[3:0];

    always_comb
    begin
        cmd        = '0;
        cmd.cnt    = cnt_reg;
        cmd.ch     = cfg.position[{drv_idx, 1'b1}];
        if (!drv_ok)
        begin
            cmd.kind   = KIND_STATUS;
            cmd.status = ST_NO_DRIVE;
        end
        else if (range_bad)
        begin
            cmd.kind   = KIND_STATUS;
            cmd.status = ST_RANGE;
        end
        else if (is_atapi)
        begin
            cmd.kind   = dir_reg ? KIND_STATUS : KIND_NONE;
            cmd.status = ST_WPROT;
        end
        else
        begin
            cmd.kind   = KIND_WRITES;
            cmd.status = ST_OK;
        end

        if (lba_reg >= LBA48_START)
        begin
            cmd.mode   = MODE_LBA48;
            cmd.b0     = lba_reg[7:0];
            cmd.b1     = lba_reg[15:8];
            cmd.b2     = lba_reg[23:16];
            cmd.b3     = lba_reg[31:24];
            cmd.devsel = DEVSEL_LBA | {3'd0, cfg.position[{drv_idx, 1'b0}], 4'd0};
            cmd.opcode = dir_reg ? (dma_reg ? CMD_WRITE_DMA_EXT : CMD_WRITE_PIO_EXT)
                                 : (dma_reg ? CMD_READ_DMA_EXT : CMD_READ_PIO_EXT);
        end
        else if (cfg.lba[drv_idx])
        begin
            cmd.mode   = MODE_LBA28;
            cmd.b0     = lba_reg[7:0];
            cmd.b1     = lba_reg[15:8];
            cmd.b2     = lba_reg[23:16];
            cmd.devsel = DEVSEL_LBA | {3'd0, cfg.position[{drv_idx, 1'b0}], lba_reg[27:24]};
            cmd.opcode = dir_reg ? (dma_reg ? CMD_WRITE_DMA : CMD_WRITE_PIO)
                                 : (dma_reg ? CMD_READ_DMA : CMD_READ_PIO);
        end
        else
        begin
            cmd.mode   = MODE_CHS;
            cmd.b0     = sector;
            cmd.b1     = cyl[7:0];
            cmd.b2     = cyl[15:8];
            cmd.devsel = DEVSEL_CHS | {3'd0, cfg.position[{drv_idx, 1'b0}], head};
            cmd.opcode = dir_reg ? (dma_reg ? CMD_WRITE_DMA : CMD_WRITE_PIO)
                                 : (dma_reg ? CMD_READ_DMA : CMD_READ_PIO);
        end
    end

    // Drop an ATAPI read at once; otherwise wait for the sequencer
    assign consumed  = req_valid_reg && ((cmd.kind == KIND_NONE) || seq_free);
    assign in_stall  = req_valid_reg && !consumed;
    assign load      = in_valid && !in_stall;
    assign cmd_valid = req_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            req_valid_reg <= 1'b1;
        end
        else if (consumed)
        begin
            req_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dir_reg <= direction;
            dma_reg <= use_dma;
            drv_reg <= drive_number;
            lba_reg <= block_address;
            cnt_reg <= sector_count;
        end
    end

endmodule

`default_nettype wire

>>> hdl/atatf_seq.sv
// Write sequencer: holds one command descriptor and issues its task-file
// writes or status transfer via output register. Depends on atatf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module atatf_seq
    import atatf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    input  wire cmd_t       cmd,
    output logic            seq_free,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            is_reg_write,
    output logic            channel_select,
    output logic [3:0]      reg_offset,
    output logic [7:0]      reg_value,
    output logic [1:0]      status_code,
    output logic [1:0]      addr_mode,
    output logic            last_item
);

    logic       busy_reg;
    logic       busy_next;
    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    cmd_t       desc_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       wr_reg;
    logic       ch_reg;
    logic [3:0] off_reg;
    logic [7:0] val_reg;
    logic [1:0] st_reg;
    logic [1:0] mode_reg;
    logic       last_reg;

    logic       emit;
    logic       cur_last;
    logic       load;
    logic       is_status;
    logic [7:0] cur_value;

    assign is_status = desc_reg.kind == KIND_STATUS;
    assign emit      = busy_reg && (!out_valid_reg || !out_stall);
    assign cur_last  = is_status || (pos_reg == SEQ_LAST);
    assign seq_free  = !busy_reg || (emit && cur_last);
    assign load      = cmd_valid && (cmd.kind != KIND_NONE) && seq_free;

    always_comb
    begin
        case (pos_reg)
            4'd0:    cur_value = desc_reg.devsel;
            4'd2:    cur_value = desc_reg.b3;
            4'd5:    cur_value = desc_reg.cnt;
            4'd6:    cur_value = desc_reg.b0;
            4'd7:    cur_value = desc_reg.b1;
            4'd8:    cur_value = desc_reg.b2;
            4'd9:    cur_value = desc_reg.opcode;
            default: cur_value = 8'd0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (load)
        begin
            busy_next = 1'b1;
            pos_next  = SEQ_DEVSEL;
        end
        else if (emit)
        begin
            if (cur_last)
            begin
                busy_next = 1'b0;
            end
            // skip the LBA48 high part for the short forms
            if ((pos_reg == SEQ_DEVSEL) && (desc_reg.mode != MODE_LBA48))
            begin
                pos_next = SEQ_COUNT;
            end
            else
            begin
                pos_next = pos_reg + 4'd1;
            end
        end
    end

    assign out_valid_next = emit || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= SEQ_DEVSEL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            desc_reg <= cmd;
        end
        if (emit)
        begin
            if (is_status)
            begin
                wr_reg   <= 1'b0;
                ch_reg   <= 1'b0;
                off_reg  <= 4'd0;
                val_reg  <= 8'd0;
                st_reg   <= desc_reg.status;
                mode_reg <= MODE_CHS;
                last_reg <= 1'b1;
            end
            else
            begin
                wr_reg   <= 1'b1;
                ch_reg   <= desc_reg.ch;
                off_reg  <= seq_offset(pos_reg);
                val_reg  <= cur_value;
                st_reg   <= ST_OK;
                mode_reg <= desc_reg.mode;
                last_reg <= cur_last;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign is_reg_write   = wr_reg;
    assign channel_select = ch_reg;
    assign reg_offset     = off_reg;
    assign reg_value      = val_reg;
    assign status_code    = st_reg;
    assign addr_mode      = mode_reg;
    assign last_item      = last_reg;

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !wr_reg |-> last_reg)
        else $error("status transfer not marked last");

    a_cmd_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && wr_reg |-> ((off_reg == REG_COMMAND) == last_reg)
                                    && (st_reg == ST_OK))
        else $error("command write and last flag disagree");

    a_short_skip: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && (desc_reg.kind == KIND_WRITES) && (desc_reg.mode != MODE_LBA48)
        |-> !((pos_reg != SEQ_DEVSEL) && (pos_reg <= SEQ_HIGH_END)))
        else $error("LBA48 high part issued for short addressing");

endmodule

`default_nettype wire
